// ----- rtl/dsl_pkg.sv -----
`timescale 1ns / 1ps

package dsl_pkg;

	// Number of cells in the row.
	localparam int DEPTH = 16;

	// Field widths of the request and response.
	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;
	localparam int ECNT_W  = 5;

	// Width of the fill count and of a cell index.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	// Request modes.
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	// Response status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} req_t;

	typedef struct packed {
		logic                      found;
		logic signed [VALUE_W-1:0] read_value;
		logic [ECNT_W-1:0]         element_count;
		logic [1:0]                status;
	} rsp_t;

	// Control handed to one cell.
	typedef struct packed {
		logic ins_en;
		logic prev_take;
		logic row_valid;
	} cell_ctl_t;

	// Flags reported by one cell.
	typedef struct packed {
		logic take;
		logic hit;
	} cell_flag_t;

endpackage

// ----- rtl/dsl_cell.sv -----
`timescale 1ns / 1ps

module dsl_cell
	import dsl_pkg::*;
(
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic signed [VALUE_W-1:0] key,
	input  logic signed [VALUE_W-1:0] prev_value,
	output logic signed [VALUE_W-1:0] value,
	output cell_flag_t                flag
);

	logic signed [VALUE_W-1:0] value_q;

	// The new key belongs at or above this cell when the cell is empty or smaller.
	// Equal values stay above the new one.
	assign flag.take = !ctl.row_valid || (value_q < key);
	assign flag.hit  = ctl.row_valid && (value_q == key);
	assign value     = value_q;

	// On an insert, cells below the slot take their upper neighbor's value,
	// and the slot cell itself takes the key.
	always_ff @(posedge clk) begin
		if (ctl.ins_en && flag.take) begin
			if (ctl.prev_take) begin
				value_q <= prev_value;
			end else begin
				value_q <= key;
			end
		end
	end

endmodule

// ----- rtl/descending_sorted_list_core.sv -----
`timescale 1ns / 1ps

// Sorted store of up to DEPTH signed 32-bit values kept in descending order
// in a row of cells. Each request (insert, search, or read at a 1-based
// position) is answered by one response from an output register in the
// cycle after it is accepted; a new request is taken every cycle as long
// as the response side keeps up, since all cells compare against the request
// in parallel and shift in the same edge. Inserts into a full store are
// refused with status full, reads at position zero or past the count return
// status out of range, and the unused mode is answered without effect.
module descending_sorted_list_core
	import dsl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int EXT_W = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

	logic                      accept;
	logic                      full;
	logic                      ins_en;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          cnt_next;
	logic [EXT_W-1:0]          cnt_ext;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;
	rsp_t                      rsp_d;
	logic [DEPTH-1:0]          hits;
	logic [DEPTH-1:0]          takes;
	logic signed [VALUE_W-1:0] cell_val [DEPTH];
	logic [CMP_W-1:0]          pos_ext;
	logic [CMP_W-1:0]          cnt_cmp;
	logic                      pos_ok;
	logic [POS_W-1:0]          pos_m1;
	logic [IDX_W-1:0]          rd_idx;

	// A new request waits only while a response is held and stalled.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign ins_en    = accept && (req.mode == MODE_INSERT) && !full;

	// Row of cells; cell 0 holds the largest value.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t                 ctl;
		cell_flag_t                flag;
		logic signed [VALUE_W-1:0] prev_value;

		if (i == 0) begin : g_head
			assign ctl.prev_take = 1'b0;
			assign prev_value    = req.value;
		end else begin : g_body
			assign ctl.prev_take = takes[i-1];
			assign prev_value    = cell_val[i-1];
		end

		assign ctl.ins_en    = ins_en;
		assign ctl.row_valid = (CNT_W'(i) < cnt_q);

		dsl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.key        (req.value),
			.prev_value (prev_value),
			.value      (cell_val[i]),
			.flag       (flag)
		);

		assign takes[i] = flag.take;
		assign hits[i]  = flag.hit;
	end

	// Read position check and cell select.
	assign pos_ext = CMP_W'(req.position);
	assign cnt_cmp = CMP_W'(cnt_q);
	assign pos_ok  = (req.position != '0) && (pos_ext <= cnt_cmp);
	assign pos_m1  = req.position - POS_W'(1);
	assign rd_idx  = pos_m1[IDX_W-1:0];

	assign cnt_next = ins_en ? cnt_q + CNT_W'(1) : cnt_q;
	assign cnt_ext  = EXT_W'(cnt_next);

	// Response for the request in flight.
	always_comb begin
		rsp_d               = '0;
		rsp_d.element_count = cnt_ext[ECNT_W-1:0];
		rsp_d.status        = STATUS_OK;
		unique case (req.mode)
			MODE_INSERT: begin
				if (full) begin
					rsp_d.status = STATUS_FULL;
				end
			end
			MODE_SEARCH: begin
				rsp_d.found = |hits;
			end
			MODE_READ: begin
				if (pos_ok) begin
					rsp_d.found      = 1'b1;
					rsp_d.read_value = cell_val[rd_idx];
				end else begin
					rsp_d.status = STATUS_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	// Fill count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import dsl_pkg::*;

	// The fourth mode code has no function and must leave the store alone.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

	// Random requests per idling phase, not counting the ignored mode.
	localparam int PHASE_REQUESTS = 580;

	// Tracks the sorted store and checks every response against it.
	class sorted_list_scoreboard;
		logic signed [VALUE_W-1:0] cells [DEPTH];
		int unsigned held = 0;
		rsp_t expected_q [$];
		int errors = 0;
		int accepted = 0;
		int checked = 0;
		int hits = 0;
		int refused = 0;
		int out_of_range = 0;

		// Apply one accepted request to the store and queue its response.
		function void note_request(req_t r);
			rsp_t e;
			logic signed [VALUE_W-1:0] v;
			int unsigned slot;
			e = '0;
			v = r.value;
			accepted++;
			case (r.mode)
				MODE_INSERT: begin
					if (held >= DEPTH) begin
						e.status = STATUS_FULL;
						refused++;
					end else begin
						// Equal values stay ahead of the new one.
						slot = 0;
						while (slot < held && cells[slot] >= v)
							slot++;
						for (int i = held; i > slot; i--)
							cells[i] = cells[i - 1];
						cells[slot] = v;
						held++;
					end
				end
				MODE_SEARCH: begin
					for (int i = 0; i < held; i++)
						if (cells[i] == v)
							e.found = 1'b1;
					if (e.found)
						hits++;
				end
				MODE_READ: begin
					if (r.position >= 1 && r.position <= held) begin
						e.found = 1'b1;
						e.read_value = cells[r.position - 1];
					end else begin
						e.status = STATUS_RANGE;
						out_of_range++;
					end
				end
				default: begin
				end
			endcase
			e.element_count = ECNT_W'(held);
			expected_q.push_back(e);
		endfunction

		// Compare one accepted response with the oldest expectation.
		task check_response(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				report("response with no request waiting", got.read_value, '0);
			end else begin
				e = expected_q.pop_front();
				checked++;
				if (got.found !== e.found)
					report("found", got.found, e.found);
				if (got.read_value !== e.read_value)
					report("read_value", got.read_value, e.read_value);
				if (got.element_count !== e.element_count)
					report("element_count", got.element_count, e.element_count);
				if (got.status !== e.status)
					report("status", got.status, e.status);
			end
		endtask

		// Print one line per mismatch, up to a cap, and count them all.
		task report(string what, logic [31:0] got_v, logic [31:0] exp_v);
			errors++;
			if (errors <= 50)
				$display("[%0t] mismatch on %s: got %0h, expected %0h",
					$time, what, got_v, exp_v);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	sorted_list_scoreboard sb = new();

	// Values the stimulus has put into the store, in the order they went in.
	logic signed [VALUE_W-1:0] pool [$];
	int send_idle_pct = 28;
	int stall_pct = 75;

	descending_sorted_list_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// Response side stalls at random.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watch both handshakes. The request is noted first so that a response
	// in the same edge still finds its expectation queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#500000;
		$display("FAILURE");
		$finish;
	end

	function automatic req_t make_req(logic [1:0] m, logic signed [VALUE_W-1:0] v,
			logic [POS_W-1:0] p);
		req_t r;
		r.mode = m;
		r.value = v;
		r.position = p;
		return r;
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	task automatic send_request(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		if (r.mode == MODE_INSERT && pool.size() < DEPTH)
			pool.push_back(r.value);
	endtask

	// Insert values lean toward extremes and small values so duplicates occur.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 10) begin
			case ($urandom_range(3))
				0: return VALUE_MAX;
				1: return VALUE_MIN;
				2: return '0;
				default: return '1;
			endcase
		end
		if (sel < 35)
			return 32'($urandom_range(8)) - 32'd4;
		if (sel < 50 && pool.size() > 0)
			return pool[$urandom_range(pool.size() - 1)];
		return $urandom();
	endfunction

	// Mostly meaningful requests: searches for held values and reads near
	// the fill level, with a slow trickle of inserts until the store is full, more after.
	function automatic req_t random_request();
		req_t r;
		int unsigned sel;
		int unsigned ins_pct;
		int unsigned k;
		r.mode = MODE_SEARCH;
		r.value = $urandom();
		r.position = POS_W'($urandom());
		ins_pct = (pool.size() < DEPTH) ? 6 : 20;
		sel = $urandom_range(99);
		if (sel < 5) begin
			r.mode = MODE_UNUSED;
		end else if (sel < 5 + ins_pct) begin
			r.mode = MODE_INSERT;
			r.value = pick_value();
		end else if (sel < 5 + ins_pct + (95 - ins_pct) / 2) begin
			r.mode = MODE_SEARCH;
			sel = $urandom_range(99);
			if (pool.size() > 0 && sel < 80) begin
				k = $urandom_range(pool.size() - 1);
				if (sel < 60)
					r.value = pool[k];
				else if (sel < 70)
					r.value = pool[k] + 32'sd1;
				else
					r.value = pool[k] - 32'sd1;
			end else begin
				r.value = pick_value();
			end
		end else begin
			r.mode = MODE_READ;
			if ($urandom_range(99) < 70)
				r.position = POS_W'($urandom_range(pool.size() + 1));
		end
		return r;
	endfunction

	// Main sequence: reset, directed requests, then three idling phases.
	initial begin
		req_t r;
		int n;
		int guard;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store: reads out of range, search misses, unused mode.
		send_request(make_req(MODE_READ, '0, 8'd0));
		send_request(make_req(MODE_READ, '0, 8'd1));
		send_request(make_req(MODE_SEARCH, '0, '0));
		send_request(make_req(MODE_UNUSED, '0, '0));
		// Extremes and duplicates going in.
		send_request(make_req(MODE_INSERT, VALUE_MAX, '0));
		send_request(make_req(MODE_INSERT, VALUE_MIN, '0));
		send_request(make_req(MODE_INSERT, '0, '1));
		send_request(make_req(MODE_INSERT, '0, '0));
		send_request(make_req(MODE_INSERT, '1, '0));
		send_request(make_req(MODE_INSERT, VALUE_MAX, '0));
		// Searches that hit and miss, reads across the whole position range.
		send_request(make_req(MODE_SEARCH, VALUE_MIN, '0));
		send_request(make_req(MODE_SEARCH, 32'sd1, '0));
		send_request(make_req(MODE_SEARCH, '1, '1));
		send_request(make_req(MODE_READ, '0, 8'd1));
		send_request(make_req(MODE_READ, '1, 8'd6));
		send_request(make_req(MODE_READ, '0, 8'd7));
		send_request(make_req(MODE_READ, '0, 8'd255));
		send_request(make_req(MODE_UNUSED, '1, 8'd255));

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 28;
					stall_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					stall_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			n = 0;
			while (n < PHASE_REQUESTS) begin
				r = random_request();
				send_request(r);
				if (r.mode != MODE_UNUSED)
					n++;
			end
		end
		req_valid <= 1'b0;

		// Drain the outstanding responses, then watch for strays.
		guard = 0;
		while (sb.expected_q.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		if (sb.expected_q.size() != 0)
			sb.report("responses still missing", sb.expected_q.size(), 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests and checked %0d responses under three idling mixes.",
			sb.accepted, sb.checked);
		$display("Saw %0d search hits, %0d refused inserts, %0d out-of-range reads.",
			sb.hits, sb.refused, sb.out_of_range);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- descending_sorted_list_core.f -----
rtl/dsl_pkg.sv
rtl/dsl_cell.sv
rtl/descending_sorted_list_core.sv
verif/tb.sv
